/* design/page_framebuffer_draw_engine_core_defines.svh */
// assertion macros for the draw engine checker
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
// implication checked on every clock outside reset
`define PFDE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define PFDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* design/pfde_pkg.sv */
// types, constants and font table for the page frame buffer draw engine
`default_nettype none
package pfde_pkg;
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_SET = 3'd1;
  localparam logic [2:0] OP_GET = 3'd2;
  localparam logic [2:0] OP_FILL = 3'd3;
  localparam logic [2:0] OP_OUTLINE = 3'd4;
  localparam logic [2:0] OP_GLYPH = 3'd5;
  localparam logic [2:0] OP_READ = 3'd6;

  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST = 8'd95;
  localparam logic [2:0] GLYPH_COLS = 3'd5;
  localparam logic [2:0] GLYPH_ROWS = 3'd7;
  localparam logic [2:0] GLYPH_ADVANCE = 3'd6;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       ink;
    logic [7:0] char_code;
    logic [9:0] byte_index;
  } cmd_t;

  typedef struct packed {
    logic       pixel_value;
    logic [2:0] char_advance;
    logic [7:0] byte_data;
  } rsp_t;

  function automatic logic [6:0] glyph_col(input logic [5:0] g, input logic [2:0] c);
    logic [34:0] r;
    case (g)
      6'd0: r = {7'h00,7'h00,7'h00,7'h00,7'h00};
      6'd1: r = {7'h00,7'h00,7'h5F,7'h00,7'h00};
      6'd2: r = {7'h00,7'h07,7'h00,7'h07,7'h00};
      6'd3: r = {7'h14,7'h7F,7'h14,7'h7F,7'h14};
      6'd4: r = {7'h24,7'h2A,7'h7F,7'h2A,7'h12};
      6'd5: r = {7'h23,7'h13,7'h08,7'h64,7'h62};
      6'd6: r = {7'h36,7'h49,7'h55,7'h22,7'h50};
      6'd7: r = {7'h00,7'h05,7'h03,7'h00,7'h00};
      6'd8: r = {7'h00,7'h1C,7'h22,7'h41,7'h00};
      6'd9: r = {7'h00,7'h41,7'h22,7'h1C,7'h00};
      6'd10: r = {7'h08,7'h2A,7'h1C,7'h2A,7'h08};
      6'd11: r = {7'h08,7'h08,7'h3E,7'h08,7'h08};
      6'd12: r = {7'h00,7'h50,7'h30,7'h00,7'h00};
      6'd13: r = {7'h08,7'h08,7'h08,7'h08,7'h08};
      6'd14: r = {7'h00,7'h60,7'h60,7'h00,7'h00};
      6'd15: r = {7'h20,7'h10,7'h08,7'h04,7'h02};
      6'd16: r = {7'h3E,7'h51,7'h49,7'h45,7'h3E};
      6'd17: r = {7'h00,7'h42,7'h7F,7'h40,7'h00};
      6'd18: r = {7'h42,7'h61,7'h51,7'h49,7'h46};
      6'd19: r = {7'h21,7'h41,7'h45,7'h4B,7'h31};
      6'd20: r = {7'h18,7'h14,7'h12,7'h7F,7'h10};
      6'd21: r = {7'h27,7'h45,7'h45,7'h45,7'h39};
      6'd22: r = {7'h3C,7'h4A,7'h49,7'h49,7'h30};
      6'd23: r = {7'h01,7'h71,7'h09,7'h05,7'h03};
      6'd24: r = {7'h36,7'h49,7'h49,7'h49,7'h36};
      6'd25: r = {7'h06,7'h49,7'h49,7'h29,7'h1E};
      6'd26: r = {7'h00,7'h36,7'h36,7'h00,7'h00};
      6'd27: r = {7'h00,7'h56,7'h36,7'h00,7'h00};
      6'd28: r = {7'h00,7'h08,7'h14,7'h22,7'h41};
      6'd29: r = {7'h14,7'h14,7'h14,7'h14,7'h14};
      6'd30: r = {7'h41,7'h22,7'h14,7'h08,7'h00};
      6'd31: r = {7'h02,7'h01,7'h51,7'h09,7'h06};
      6'd32: r = {7'h32,7'h49,7'h79,7'h41,7'h3E};
      6'd33: r = {7'h7E,7'h11,7'h11,7'h11,7'h7E};
      6'd34: r = {7'h7F,7'h49,7'h49,7'h49,7'h36};
      6'd35: r = {7'h3E,7'h41,7'h41,7'h41,7'h22};
      6'd36: r = {7'h7F,7'h41,7'h41,7'h22,7'h1C};
      6'd37: r = {7'h7F,7'h49,7'h49,7'h49,7'h41};
      6'd38: r = {7'h7F,7'h09,7'h09,7'h01,7'h01};
      6'd39: r = {7'h3E,7'h41,7'h41,7'h51,7'h32};
      6'd40: r = {7'h7F,7'h08,7'h08,7'h08,7'h7F};
      6'd41: r = {7'h00,7'h41,7'h7F,7'h41,7'h00};
      6'd42: r = {7'h20,7'h40,7'h41,7'h3F,7'h01};
      6'd43: r = {7'h7F,7'h08,7'h14,7'h22,7'h41};
      6'd44: r = {7'h7F,7'h40,7'h40,7'h40,7'h40};
      6'd45: r = {7'h7F,7'h02,7'h04,7'h02,7'h7F};
      6'd46: r = {7'h7F,7'h04,7'h08,7'h10,7'h7F};
      6'd47: r = {7'h3E,7'h41,7'h41,7'h41,7'h3E};
      6'd48: r = {7'h7F,7'h09,7'h09,7'h09,7'h06};
      6'd49: r = {7'h3E,7'h41,7'h51,7'h21,7'h5E};
      6'd50: r = {7'h7F,7'h09,7'h19,7'h29,7'h46};
      6'd51: r = {7'h46,7'h49,7'h49,7'h49,7'h31};
      6'd52: r = {7'h01,7'h01,7'h7F,7'h01,7'h01};
      6'd53: r = {7'h3F,7'h40,7'h40,7'h40,7'h3F};
      6'd54: r = {7'h1F,7'h20,7'h40,7'h20,7'h1F};
      6'd55: r = {7'h7F,7'h20,7'h18,7'h20,7'h7F};
      6'd56: r = {7'h63,7'h14,7'h08,7'h14,7'h63};
      6'd57: r = {7'h03,7'h04,7'h78,7'h04,7'h03};
      6'd58: r = {7'h61,7'h51,7'h49,7'h45,7'h43};
      6'd59: r = {7'h00,7'h00,7'h7F,7'h41,7'h41};
      6'd60: r = {7'h02,7'h04,7'h08,7'h10,7'h20};
      6'd61: r = {7'h41,7'h41,7'h7F,7'h00,7'h00};
      6'd62: r = {7'h04,7'h02,7'h01,7'h02,7'h04};
      default: r = {7'h40,7'h40,7'h40,7'h40,7'h40};
    endcase
    case (c)
      3'd0: glyph_col = r[34:28];
      3'd1: glyph_col = r[27:21];
      3'd2: glyph_col = r[20:14];
      3'd3: glyph_col = r[13:7];
      default: glyph_col = r[6:0];
    endcase
  endfunction
endpackage
`default_nettype wire

/* design/pfde_store.sv */
// frame store memory with one read and one write port, registered read
`default_nettype none
module pfde_store #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/page_framebuffer_draw_engine_core.sv */
// page frame buffer draw engine: pixels are drawn by read-modify-write
// set/get pixel: address, then read-modify-write, then result; read byte: read, then result
// fill/outline visit each pixel in turn (outline visits 2w+2h); glyph visits 5*7 = 35 pixels
// clear: one store byte per cycle; a command that draws nothing goes straight to its result
// items are handled one at a time; a stalled result holds off the next item
// reset (synchronous) runs a clearing pass over all PANEL_WIDTH*pages store bytes, no item accepted
`default_nettype none
module page_framebuffer_draw_engine_core #(
  parameter int PANEL_WIDTH = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pfde_pkg::cmd_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pfde_pkg::rsp_t       out_data
);
  import pfde_pkg::*;

  localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int DEPTH = PANEL_WIDTH * PAGES;
  localparam int AW = $clog2(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;   // present pixel address
  localparam logic [2:0] S_MOD = 3'd3;    // read data back, write modified byte
  localparam logic [2:0] S_RDB = 3'd4;    // byte read issued
  localparam logic [2:0] S_RDB2 = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;

  logic [2:0] state;
  cmd_t cmd;
  // walk counters: i along columns, j along rows
  logic [8:0] ci, cj;
  logic [1:0] side;       // outline: which edge
  logic [AW:0] clr_addr;
  rsp_t rsp;

  // current pixel coordinates and color from the walk
  logic [8:0] px, py;
  logic pon;
  logic [8:0] w9, h9;
  assign w9 = {1'b0, cmd.rect_width};
  assign h9 = {1'b0, cmd.rect_height};

  // font column under the walk
  logic [6:0] gcol;
  assign gcol = glyph_col(6'(cmd.char_code - GLYPH_FIRST), ci[2:0]);

  always_comb begin
    px = {1'b0, cmd.pos_x};
    py = {1'b0, cmd.pos_y};
    pon = cmd.ink;
    case (cmd.opcode)
      OP_FILL: begin
        px = {1'b0, cmd.pos_x} + ci;
        py = {1'b0, cmd.pos_y} + cj;
      end
      OP_OUTLINE: begin
        case (side)
          2'd0: begin px = {1'b0, cmd.pos_x} + ci; py = {1'b0, cmd.pos_y}; end
          2'd1: begin
            px = {1'b0, cmd.pos_x} + ci;
            py = {1'b0, cmd.pos_y} + h9 - 9'd1;
          end
          2'd2: begin px = {1'b0, cmd.pos_x}; py = {1'b0, cmd.pos_y} + cj; end
          default: begin
            px = {1'b0, cmd.pos_x} + w9 - 9'd1;
            py = {1'b0, cmd.pos_y} + cj;
          end
        endcase
      end
      OP_GLYPH: begin
        px = {1'b0, cmd.pos_x} + ci;
        py = {1'b0, cmd.pos_y} + cj;
        pon = gcol[cj[2:0]];
      end
      default: ;
    endcase
  end

  // px, py are under 512 so sums cannot wrap
  logic on_panel;
  assign on_panel = (px < 9'(PANEL_WIDTH)) && (py < 9'(PANEL_HEIGHT));
  logic [AW-1:0] paddr;
  assign paddr = AW'(({3'b0, py[8:3]} * 12'(PANEL_WIDTH)) + {3'b0, px});

  logic [AW-1:0] raddr, waddr;
  logic [7:0] rdata, wdata;
  logic we;
  logic [AW-1:0] hold_addr;
  logic hold_on, hold_ok, hold_last;
  logic [2:0] hold_bit;

  // walk end and advance for the multi-pixel commands
  logic last;
  logic [8:0] ci_next, cj_next;
  logic [1:0] side_next;
  always_comb begin
    last = 1'b1;
    ci_next = ci;
    cj_next = cj;
    side_next = side;
    case (cmd.opcode)
      OP_FILL: begin
        if (ci + 9'd1 < w9) begin
          ci_next = ci + 9'd1; last = 1'b0;
        end else if (cj + 9'd1 < h9) begin
          ci_next = '0; cj_next = cj + 9'd1; last = 1'b0;
        end
      end
      OP_OUTLINE: begin
        if ((side[1] == 1'b0) && (ci + 9'd1 < w9)) begin
          ci_next = ci + 9'd1; last = 1'b0;
        end else if ((side[1] == 1'b1) && (cj + 9'd1 < h9)) begin
          cj_next = cj + 9'd1; last = 1'b0;
        end else if (side != 2'd3) begin
          side_next = side + 2'd1; ci_next = '0; cj_next = '0; last = 1'b0;
        end
      end
      OP_GLYPH: begin
        if (cj + 9'd1 < 9'(GLYPH_ROWS)) begin
          cj_next = cj + 9'd1; last = 1'b0;
        end else if (ci + 9'd1 < 9'(GLYPH_COLS)) begin
          cj_next = '0; ci_next = ci + 9'd1; last = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    raddr = paddr;
    if (state == S_IDLE) raddr = AW'(in_data.byte_index);
    else if (state == S_RDB) raddr = AW'(cmd.byte_index);
    we = 1'b0;
    waddr = hold_addr;
    wdata = hold_on ? (rdata | (8'd1 << hold_bit)) : (rdata & ~(8'd1 << hold_bit));
    if (state == S_CLR) begin
      we = 1'b1; waddr = clr_addr[AW-1:0]; wdata = '0;
    end else if (state == S_MOD && hold_ok && cmd.opcode != OP_GET) begin
      we = 1'b1;
    end
  end

  pfde_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .raddr(raddr), .rdata(rdata), .we(we), .waddr(waddr), .wdata(wdata)
  );

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data = rsp;

  logic glyph_ok;
  assign glyph_ok = (in_data.char_code >= GLYPH_FIRST) && (in_data.char_code <= GLYPH_LAST);

  // marks that the running clear pass belongs to reset, not to a command
  logic cmd_is_reset;
  always_ff @(posedge clk) begin
    if (rst) cmd_is_reset <= 1'b1;
    else if (state == S_IDLE) cmd_is_reset <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          cmd <= in_data;
          ci <= '0; cj <= '0; side <= '0;
          rsp.pixel_value <= 1'b0;
          rsp.byte_data <= '0;
          rsp.char_advance <= (in_data.opcode == OP_GLYPH && glyph_ok) ? GLYPH_ADVANCE : 3'd0;
          clr_addr <= '0;
          case (in_data.opcode)
            OP_CLEAR: state <= S_CLR;
            OP_SET, OP_GET: state <= S_ADDR;
            OP_FILL, OP_OUTLINE: state <= (in_data.rect_width == 8'd0 ||
                                          in_data.rect_height == 8'd0) ? S_OUT : S_ADDR;
            OP_GLYPH: state <= glyph_ok ? S_ADDR : S_OUT;
            OP_READ: state <= (32'(in_data.byte_index) < DEPTH) ? S_RDB : S_OUT;
            default: state <= S_OUT;
          endcase
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          // the reset clearing pass ends without a result
          if (clr_addr == (AW+1)'(DEPTH - 1)) state <= cmd_is_reset ? S_IDLE : S_OUT;
        end
        S_ADDR: begin
          hold_addr <= paddr;
          hold_bit <= py[2:0];
          hold_on <= pon;
          hold_ok <= on_panel;
          hold_last <= last;
          ci <= ci_next; cj <= cj_next; side <= side_next;
          state <= S_MOD;
        end
        S_MOD: begin
          if (cmd.opcode == OP_GET) begin
            rsp.pixel_value <= hold_ok & rdata[hold_bit];
            state <= S_OUT;
          end else begin
            state <= (cmd.opcode == OP_SET || hold_last) ? S_OUT : S_ADDR;
          end
        end
        S_RDB: state <= S_RDB2;
        S_RDB2: begin
          rsp.byte_data <= rdata;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // note: the walk end is latched with the pixel address in S_ADDR, since
  // ci/cj have already advanced by the time S_MOD decides where to go
endmodule
`default_nettype wire

/* design/pfde_checker.sv */
// port-level checker for the draw engine, bound to the top level
`default_nettype none
`include "page_framebuffer_draw_engine_core_defines.svh"
module pfde_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire pfde_pkg::rsp_t out_data
);
  import pfde_pkg::*;
  logic out_stall, adv_ok;
  assign out_stall = out_valid && !out_ready;
  assign adv_ok = (out_data.char_advance == 3'd0) || (out_data.char_advance == GLYPH_ADVANCE);
  `PFDE_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready, "busy while result pending")
  `PFDE_ASSERT_NEXT(a_hold, clk, rst, out_stall, out_valid && $stable(out_data), "result dropped")
  `PFDE_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready, "ready during work")
  `PFDE_ASSERT_IMP(a_adv, clk, rst, out_valid, adv_ok, "bad advance")
endmodule

bind page_framebuffer_draw_engine_core pfde_checker u_pfde_checker (.*);
`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for the page frame buffer draw engine
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import pfde_pkg::*;

  localparam int PANEL_W = 128;
  localparam int PANEL_H = 64;
  localparam int STORE_SIZE = PANEL_W * ((PANEL_H + 7) / 8);
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 6000000;
  // receiver hold-off window, counted in the receiver's own cycles; it lands
  // on the directed items just after the reset clearing pass
  localparam int HOLD_START = 1200;
  localparam int HOLD_LEN = 800;
  // drain wait covers a clear of the whole store
  localparam int DRAIN_CYCLES = 3 * STORE_SIZE;

  // 5x7 font, codes 32 to 95, five column bytes per glyph, bit 0 on top
  localparam logic [8*320-1:0] FONT_BITS = {
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
    8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
    8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00,
    8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
    8'h08,8'h2A,8'h1C,8'h2A,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
    8'h00,8'h08,8'h14,8'h22,8'h41, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h41,8'h22,8'h14,8'h08,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,
    8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7E,8'h11,8'h11,8'h11,8'h7E,
    8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h7F,8'h49,8'h49,8'h49,8'h41,
    8'h7F,8'h09,8'h09,8'h01,8'h01, 8'h3E,8'h41,8'h41,8'h51,8'h32,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
    8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
    8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h46,8'h49,8'h49,8'h49,8'h31,
    8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h7F,8'h20,8'h18,8'h20,8'h7F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h03,8'h04,8'h78,8'h04,8'h03,
    8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h41,8'h41,8'h7F,8'h00,8'h00,
    8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40
  };

  typedef struct {
    cmd_t cmd;
    bit   fixed;   // expected result typed in below
    rsp_t rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  // predictor state: shadow of the frame store
  logic [7:0] shadow_store [STORE_SIZE];

  rsp_t      pending_rsp [$];   // results still owed by the block
  stim_row_t typed_rsp [$];     // per offered item: typed result, if any
  stim_row_t directed [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        rx_cycle = 0;
  bit        calm = 1'b0;       // stretch with no idling on either side

  page_framebuffer_draw_engine_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------
  // coordinates come in as plain ints so sums never wrap
  function automatic void plot(input int x, input int y, input bit on);
    int idx;
    if (x >= PANEL_W || y >= PANEL_H) return;
    idx = (y / 8) * PANEL_W + x;
    if (idx >= STORE_SIZE) return;
    shadow_store[idx][y % 8] = on;
  endfunction

  function automatic rsp_t draw_predict(input cmd_t c);
    rsp_t r;
    int x, y, w, h, g;
    logic [7:0] colbits;
    r = '0;
    x = c.pos_x;
    y = c.pos_y;
    w = c.rect_width;
    h = c.rect_height;
    case (c.opcode)
      OP_CLEAR: for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = 8'h00;
      OP_SET: plot(x, y, c.ink);
      OP_GET:
        if (x < PANEL_W && y < PANEL_H)
          r.pixel_value = shadow_store[(y / 8) * PANEL_W + x][y % 8];
      OP_FILL:
        if (w != 0 && h != 0)
          for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) plot(x + i, y + j, c.ink);
      OP_OUTLINE:
        if (w != 0 && h != 0) begin
          for (int i = 0; i < w; i++) begin
            plot(x + i, y, c.ink);
            plot(x + i, y + h - 1, c.ink);
          end
          for (int j = 0; j < h; j++) begin
            plot(x, y + j, c.ink);
            plot(x + w - 1, y + j, c.ink);
          end
        end
      OP_GLYPH:
        // glyph cell overwrites lit and unlit bits alike
        if (c.char_code >= GLYPH_FIRST && c.char_code <= GLYPH_LAST) begin
          g = c.char_code - GLYPH_FIRST;
          for (int col = 0; col < 5; col++) begin
            colbits = FONT_BITS[(319 - (g * 5 + col)) * 8 +: 8];
            for (int row = 0; row < 7; row++) plot(x + col, y + row, colbits[row]);
          end
          r.char_advance = GLYPH_ADVANCE;
        end
      OP_READ:
        if (c.byte_index < STORE_SIZE) r.byte_data = shadow_store[c.byte_index];
      default: ;  // unused opcode does nothing
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------
  // input monitor: predict at each accepted item
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    stim_row_t t;
    rsp_t p;
    if (!rst && in_valid && in_ready) begin
      p = draw_predict(in_data);
      t = typed_rsp.pop_front();
      pending_rsp.push_back(t.fixed ? t.rsp : p);
    end
  end

  // ---------------------------------------------------------------
  // output checker
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result item %h", $realtime, out_data);
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_data.pixel_value !== e.pixel_value) begin
          $display("%0t: pixel_value expected %0d actual %0d", $realtime,
                   e.pixel_value, out_data.pixel_value);
          fail_count++;
        end
        if (out_data.char_advance !== e.char_advance) begin
          $display("%0t: char_advance expected %0d actual %0d", $realtime,
                   e.char_advance, out_data.char_advance);
          fail_count++;
        end
        if (out_data.byte_data !== e.byte_data) begin
          $display("%0t: byte_data expected %h actual %h", $realtime,
                   e.byte_data, out_data.byte_data);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // receiver: random stalls, one long hold-off, calm stretch
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rst) out_ready <= 1'b0;
    else if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) out_ready <= 1'b0;
    else if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 34);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_framebuffer_draw_engine_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  function automatic cmd_t mk_cmd(input logic [2:0] op, input int x, input int y,
                                  input int w, input int h, input bit on,
                                  input int code, input int idx);
    cmd_t c;
    c.opcode = op;
    c.pos_x = x[7:0];
    c.pos_y = y[7:0];
    c.rect_width = w[7:0];
    c.rect_height = h[7:0];
    c.ink = on;
    c.char_code = code[7:0];
    c.byte_index = idx[9:0];
    return c;
  endfunction

  function automatic void add_row(input cmd_t c, input bit fixed, input rsp_t r);
    stim_row_t s;
    s.cmd = c;
    s.fixed = fixed;
    s.rsp = r;
    directed.push_back(s);
  endfunction

  function automatic rsp_t mk_rsp(input bit pv, input int adv, input int bd);
    rsp_t r;
    r.pixel_value = pv;
    r.char_advance = adv[2:0];
    r.byte_data = bd[7:0];
    return r;
  endfunction

  // random command: mostly small shapes on or near the panel
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int k;
    c = cmd_t'($bits(cmd_t)'({$urandom, $urandom}));
    k = $urandom_range(99);
    if (k < 2) c.opcode = OP_CLEAR;
    else if (k < 4) c.opcode = 3'd7;
    else if (k < 20) c.opcode = OP_SET;
    else if (k < 36) c.opcode = OP_GET;
    else if (k < 52) c.opcode = OP_FILL;
    else if (k < 66) c.opcode = OP_OUTLINE;
    else if (k < 82) c.opcode = OP_GLYPH;
    else c.opcode = OP_READ;
    if ($urandom_range(99) < 85) begin
      c.pos_x = 8'($urandom_range(PANEL_W - 1));
      c.pos_y = 8'($urandom_range(PANEL_H - 1));
    end
    k = $urandom_range(99);
    if (k < 4) begin
      // long thin shape, full width range on one side
      c.rect_width = 8'($urandom_range(255));
      c.rect_height = 8'($urandom_range(3));
    end else if (k < 8) begin
      c.rect_width = 8'($urandom_range(3));
      c.rect_height = 8'($urandom_range(255));
    end else begin
      c.rect_width = 8'($urandom_range(12));
      c.rect_height = 8'($urandom_range(12));
    end
    if ($urandom_range(99) < 75) c.char_code = 8'($urandom_range(95, 32));
    return c;
  endfunction

  task automatic send_item(input cmd_t c, input bit fixed, input rsp_t r);
    stim_row_t s;
    if (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s.cmd = c;
    s.fixed = fixed;
    s.rsp = r;
    typed_rsp.push_back(s);
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    // store is all zero after reset
    add_row(mk_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1023), 1, mk_rsp(0, 0, 0));
    // bottom right corner pixel
    add_row(mk_cmd(OP_SET, 127, 63, 0, 0, 1, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1023), 1, mk_rsp(0, 0, 8'h80));
    add_row(mk_cmd(OP_GET, 127, 63, 0, 0, 0, 0, 0), 1, mk_rsp(1, 0, 0));
    // off-panel pixels: not written, read as zero
    add_row(mk_cmd(OP_GET, 128, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_SET, 255, 255, 255, 255, 1, 255, 1023), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_GET, 255, 255, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0));
    // glyph '0' at the origin
    add_row(mk_cmd(OP_GLYPH, 0, 0, 0, 0, 0, 48, 0), 1, mk_rsp(0, 6, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 8'h3E));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 1), 1, mk_rsp(0, 0, 8'h51));
    // undrawable codes below and above the font range
    add_row(mk_cmd(OP_GLYPH, 20, 20, 0, 0, 1, 31, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_GLYPH, 20, 20, 0, 0, 1, 96, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_GLYPH, 20, 20, 0, 0, 1, 255, 0), 1, mk_rsp(0, 0, 0));
    // first and last code, the last one clipped at the corner
    add_row(mk_cmd(OP_GLYPH, 30, 8, 0, 0, 1, 32, 0), 1, mk_rsp(0, 6, 0));
    add_row(mk_cmd(OP_GLYPH, 124, 60, 0, 0, 0, 95, 0), 1, mk_rsp(0, 6, 0));
    // zero-sized rectangles draw nothing
    add_row(mk_cmd(OP_FILL, 0, 0, 0, 5, 1, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_OUTLINE, 0, 0, 5, 0, 1, 0, 0), 1, mk_rsp(0, 0, 0));
    // one full page column block, then clear a single pixel in it
    add_row(mk_cmd(OP_FILL, 0, 8, 8, 8, 1, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 128), 1, mk_rsp(0, 0, 8'hFF));
    add_row(mk_cmd(OP_SET, 0, 8, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 128), 1, mk_rsp(0, 0, 8'hFE));
    add_row(mk_cmd(OP_OUTLINE, 10, 20, 6, 5, 1, 0, 0), 0, '0);
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 2 * 128 + 12), 0, '0);
    // largest fill, then clear of the whole store
    add_row(mk_cmd(OP_FILL, 0, 0, 255, 255, 1, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 500), 1, mk_rsp(0, 0, 8'hFF));
    add_row(mk_cmd(OP_OUTLINE, 100, 40, 255, 255, 0, 0, 0), 0, '0);
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 5 * 128 + 100), 0, '0);
    add_row(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0));
    add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 500), 1, mk_rsp(0, 0, 0));
    // unused opcode
    add_row(mk_cmd(3'd7, 255, 255, 255, 255, 1, 255, 1023), 1, mk_rsp(0, 0, 0));

    for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = 8'h00;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_item(directed[i].cmd, directed[i].fixed, directed[i].rsp);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // calm stretch with neither side idling
      if (n == 600) calm = 1'b1;
      if (n == 800) calm = 1'b0;
      send_item(rand_cmd(), 0, '0);
    end
    in_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("page_framebuffer_draw_engine_core regression: pass");
    end else begin
      $display("page_framebuffer_draw_engine_core regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
